### rtl/sha1s_pkg.sv
// package: shared types and constants for the byte-serial sha-1 core
package sha1s_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam int         QDEPTH   = 2;

  typedef enum logic [0:0] {
    ACT_ABSORB = 1'b0,
    ACT_FINISH = 1'b1
  } action_t;

  // one queued request from the front end
  typedef struct packed {
    action_t    action;
    logic [7:0] data_byte;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) return K0;
    else if (r < 7'd40) return K1;
    else if (r < 7'd60) return K2;
    else return K3;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) return (b & c) | (~b & d);
    else if (r < 7'd40) return b ^ c ^ d;
    else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
    else return b ^ c ^ d;
  endfunction

endpackage

### rtl/sha1s_front.sv
// front end: accepts requests into a short queue
module sha1s_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic              action,
  input  logic [7:0]        data_byte,
  output sha1s_pkg::req_t   q_req,
  output logic              q_valid,
  input  logic              q_take
);
  import sha1s_pkg::*;

  req_t       mem [QDEPTH];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign stall   = (count == 2'(QDEPTH));
  assign push    = valid && !stall;
  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && q_take;
  assign q_req   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{action: action_t'(action), data_byte: data_byte};
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### rtl/sha1s_back.sv
// back end: block buffer, padding, 80-round compression and digest output
module sha1s_back (
  input  logic              clk,
  input  logic              rst,
  input  sha1s_pkg::req_t   q_req,
  input  logic              q_valid,
  output logic              q_take,
  output logic              valid_out,
  input  logic              stall_out,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);
  import sha1s_pkg::*;

  state_t      state, state_next;
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  // block words, big-endian bytes; doubles as the message schedule window
  logic [31:0] w [16];
  logic [6:0]  rnd;
  logic [5:0]  pad_pos;
  logic        final_blk;
  logic [2:0]  widx;
  logic [31:0] wnew, wcur, t;
  logic        out_fire;

  assign out_fire = valid_out && !stall_out;
  assign wcur = w[0];
  assign wnew = {w[13] ^ w[8] ^ w[2] ^ w[0]} << 1 | (w[13] ^ w[8] ^ w[2] ^ w[0]) >> 31;
  assign t = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + wcur;

  always_comb begin
    q_take = (state == ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_req.action == ACT_FINISH) state_next = ST_PAD;
          else if (fill == 6'd63) state_next = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (pad_pos == 6'd63) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd == 7'd79) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (!final_blk) state_next = ST_IDLE;
        else if (fill != 6'd0) state_next = ST_PAD;
        else state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire && widx == 3'd4) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // byte to place at pad_pos during padding
  logic [7:0] pad_byte;
  always_comb begin
    // length goes in the block whose tail is free of message bytes
    if (pad_pos >= LEN_POS && fill < LEN_POS)
      pad_byte = bit_len[{~pad_pos[2:0], 3'b111} -: 8];
    else if (pad_pos == fill && !final_blk) pad_byte = PAD_BYTE;
    else pad_byte = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
    end else begin
      a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      if (state == ST_IDLE && q_valid && q_req.action == ACT_ABSORB)
        w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= q_req.data_byte;
      else if (state == ST_PAD)
        w[pad_pos[5:2]][{~pad_pos[1:0], 3'b000} +: 8] <= pad_byte;
    end

    if (rst) begin
      state     <= ST_IDLE;
      fill      <= 6'd0;
      bit_len   <= 64'd0;
      rnd       <= 7'd0;
      pad_pos   <= 6'd0;
      final_blk <= 1'b0;
      widx      <= 3'd0;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          rnd <= 7'd0;
          if (q_valid) begin
            if (q_req.action == ACT_FINISH) begin
              final_blk <= 1'b0;
              pad_pos   <= fill;
            end else begin
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
            end
          end
        end
        ST_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == fill && !final_blk) final_blk <= 1'b1;
          if (pad_pos == 6'd63) begin
            // length fits in this block when fill left room
            if (fill <= 6'd55) fill <= 6'd0;
          end
        end
        ST_ROUND: rnd <= rnd + 7'd1;
        ST_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (final_blk && fill != 6'd0) begin
            fill    <= 6'd0;
            pad_pos <= 6'd0;
          end
          widx <= 3'd0;
          rnd  <= 7'd0;
        end
        ST_EMIT: begin
          if (out_fire) begin
            widx <= widx + 3'd1;
            if (widx == 3'd4) begin
              h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
              fill    <= 6'd0;
              bit_len <= 64'd0;
              final_blk <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output
  always_comb begin
    valid_out   = (state == ST_EMIT);
    digest_word = h[widx <= 3'd4 ? widx : 3'd0];
    word_index  = widx;
    last_word   = (widx == 3'd4);
  end
endmodule

### rtl/sha1_stream_hash_core.sv
// top level of the byte-serial sha-1 core
// usage:
//   input channel (valid, stall, action, data_byte) carries one request per
//   message byte (absorb) or a finish request. the front end queues up to two
//   requests so the sender keeps going while the back end compresses.
//   output channel (valid_out, stall_out, digest_word, word_index, last_word)
//   delivers five digest words A..E after each finish, last_word on E.
// sequencing:
//   absorb requests are taken only while the back end is idle; the 64th byte
//   of a block starts the 80 rounds and fold in the single shared round unit.
//   finish pads the block from fill to its end, compresses it, and when fewer
//   than 9 bytes were free pads and compresses a second block, then emits
//   one word per cycle while the receiver does not stall.
// reset:
//   synchronous rst restores the initial chaining words, empties the queue
//   and clears the byte and bit counts.
// stall:
//   a stalled digest word holds; the back end waits and the queue fills.
module sha1_stream_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        valid_out,
  input  logic        stall_out,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1s_pkg::*;

  req_t q_req;
  logic q_valid, q_take;

  sha1s_front u_front (
    .clk, .rst, .valid, .stall, .action, .data_byte,
    .q_req, .q_valid, .q_take
  );

  sha1s_back u_back (
    .clk, .rst, .q_req, .q_valid, .q_take,
    .valid_out, .stall_out, .digest_word, .word_index, .last_word
  );

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> (last_word == (word_index == 3'd4)))
    else $error("last_word mismatch");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> (word_index <= 3'd4))
    else $error("word index out of range");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (valid_out && !stall_out && !last_word) |=> (valid_out &&
      word_index == $past(word_index) + 3'd1))
    else $error("digest words not consecutive");
endmodule
